// ----- hw/rtl/qosf_pkg.sv -----
// Shared types, fixed-point constants and the step table of the observer/controller sequencer.
// No dependencies; the ALU, the top level and the testbench import this package.
`default_nettype none

package qosf_pkg;

  localparam int FRAC_BITS = 16;
  localparam int OPA_W     = 34;
  localparam int ACC_W     = 64;
  localparam int MOTOR_SH  = FRAC_BITS + 8;

  localparam logic [5:0] N_STEPS = 6'd35;

  // Coefficients: rate conversion and observer gains in Q30, flow gain in Q24,
  // feedback gains premultiplied by the mixer constants in Q8.
  localparam logic signed [31:0] K_UNIT  = 32'sd1;
  localparam logic signed [31:0] K_RADQ  = 32'sd18740330;
  localparam logic signed [31:0] K_FLOW  = 32'sd68661691;
  localparam logic signed [31:0] C_DT    = 32'sd2147484;
  localparam logic signed [31:0] C_DTG   = 32'sd21066815;
  localparam logic signed [31:0] C_OZ    = 32'sd42931774;
  localparam logic signed [31:0] C_TH    = 32'sd8012;
  localparam logic signed [31:0] C_PH    = 32'sd4626;
  localparam logic signed [31:0] C_VX    = 32'sd212360;
  localparam logic signed [31:0] C_VY    = 32'sd157758;
  localparam logic signed [31:0] C_VZ    = 32'sd187546905;
  localparam logic signed [31:0] G_EY    = 32'sd1816982;
  localparam logic signed [31:0] G_PHI   = 32'sd4243728;
  localparam logic signed [31:0] G_VY    = 32'sd1379189;
  localparam logic signed [31:0] G_WX    = 32'sd672238;
  localparam logic signed [31:0] G_EX    = 32'sd1816982;
  localparam logic signed [31:0] G_TH    = 32'sd4703808;
  localparam logic signed [31:0] G_VX    = 32'sd1439653;
  localparam logic signed [31:0] G_WY    = 32'sd685131;
  localparam logic signed [31:0] G_PSI   = 32'sd3317383;
  localparam logic signed [31:0] G_WZ    = 32'sd1536300;
  localparam logic signed [31:0] G_EZ    = 32'sd5745793;
  localparam logic signed [31:0] G_VZ    = 32'sd6644785;
  localparam logic signed [31:0] G_F0    = 32'sd9509031;

  // Operand sources of the shared multiplier.
  localparam logic [4:0] SRC_GX    = 5'd0;
  localparam logic [4:0] SRC_GY    = 5'd1;
  localparam logic [4:0] SRC_GZ    = 5'd2;
  localparam logic [4:0] SRC_ACCEL = 5'd3;
  localparam logic [4:0] SRC_FX    = 5'd4;
  localparam logic [4:0] SRC_FY    = 5'd5;
  localparam logic [4:0] SRC_RNG   = 5'd6;
  localparam logic [4:0] SRC_VX    = 5'd7;
  localparam logic [4:0] SRC_VY    = 5'd8;
  localparam logic [4:0] SRC_VZ    = 5'd9;
  localparam logic [4:0] SRC_WX    = 5'd10;
  localparam logic [4:0] SRC_WY    = 5'd11;
  localparam logic [4:0] SRC_WZ    = 5'd12;
  localparam logic [4:0] SRC_EX    = 5'd13;
  localparam logic [4:0] SRC_EY    = 5'd14;
  localparam logic [4:0] SRC_ER    = 5'd15;
  localparam logic [4:0] SRC_PITCH = 5'd16;
  localparam logic [4:0] SRC_ROLL  = 5'd17;
  localparam logic [4:0] SRC_YAW   = 5'd18;
  localparam logic [4:0] SRC_ONE   = 5'd19;
  localparam logic [4:0] SRC_PXD   = 5'd20;
  localparam logic [4:0] SRC_PYD   = 5'd21;
  localparam logic [4:0] SRC_PZD   = 5'd22;

  // Destinations; the nine estimate registers come first.
  localparam logic [4:0] DST_PX    = 5'd0;
  localparam logic [4:0] DST_PY    = 5'd1;
  localparam logic [4:0] DST_PZ    = 5'd2;
  localparam logic [4:0] DST_YAW   = 5'd3;
  localparam logic [4:0] DST_PITCH = 5'd4;
  localparam logic [4:0] DST_ROLL  = 5'd5;
  localparam logic [4:0] DST_VX    = 5'd6;
  localparam logic [4:0] DST_VY    = 5'd7;
  localparam logic [4:0] DST_VZ    = 5'd8;
  localparam logic [4:0] DST_WX    = 5'd9;
  localparam logic [4:0] DST_WY    = 5'd10;
  localparam logic [4:0] DST_WZ    = 5'd11;
  localparam logic [4:0] DST_EX    = 5'd12;
  localparam logic [4:0] DST_EY    = 5'd13;
  localparam logic [4:0] DST_ER    = 5'd14;
  localparam logic [4:0] DST_TX    = 5'd15;
  localparam logic [4:0] DST_TY    = 5'd16;
  localparam logic [4:0] DST_TZ    = 5'd17;
  localparam logic [4:0] DST_FZ    = 5'd18;

  typedef struct packed {
    logic [4:0]         src;
    logic signed [31:0] coef;
    logic               neg;
    logic               first;
    logic               last;
    logic [4:0]         dst;
  } uop_t;

  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic first;
    logic neg;
  } alu_ctl_t;

  function automatic uop_t get_uop(input logic [5:0] idx);
    uop_t u;
    u = '{src: SRC_ONE, coef: K_UNIT, neg: 1'b0, first: 1'b1, last: 1'b0, dst: DST_PX};
    unique case (idx)
      6'd0:  u = '{SRC_GX,    K_RADQ, 1'b0, 1'b1, 1'b1, DST_WX};
      6'd1:  u = '{SRC_GY,    K_RADQ, 1'b0, 1'b1, 1'b1, DST_WY};
      6'd2:  u = '{SRC_GZ,    K_RADQ, 1'b0, 1'b1, 1'b1, DST_WZ};
      6'd3:  u = '{SRC_FX,    K_FLOW, 1'b0, 1'b1, 1'b1, DST_EX};
      6'd4:  u = '{SRC_FY,    K_FLOW, 1'b0, 1'b1, 1'b1, DST_EY};
      6'd5:  u = '{SRC_RNG,   K_UNIT, 1'b0, 1'b1, 1'b1, DST_ER};
      6'd6:  u = '{SRC_VX,    C_DT,   1'b0, 1'b1, 1'b1, DST_PX};
      6'd7:  u = '{SRC_VY,    C_DT,   1'b0, 1'b1, 1'b1, DST_PY};
      6'd8:  u = '{SRC_VZ,    C_DT,   1'b0, 1'b1, 1'b0, DST_PZ};
      6'd9:  u = '{SRC_ER,    C_OZ,   1'b1, 1'b0, 1'b1, DST_PZ};
      6'd10: u = '{SRC_WZ,    C_DT,   1'b0, 1'b1, 1'b1, DST_YAW};
      6'd11: u = '{SRC_WY,    C_DT,   1'b0, 1'b1, 1'b0, DST_PITCH};
      6'd12: u = '{SRC_EX,    C_TH,   1'b1, 1'b0, 1'b1, DST_PITCH};
      6'd13: u = '{SRC_WX,    C_DT,   1'b0, 1'b1, 1'b0, DST_ROLL};
      6'd14: u = '{SRC_EY,    C_PH,   1'b0, 1'b0, 1'b1, DST_ROLL};
      6'd15: u = '{SRC_PITCH, C_DTG,  1'b0, 1'b1, 1'b0, DST_VX};
      6'd16: u = '{SRC_EX,    C_VX,   1'b1, 1'b0, 1'b1, DST_VX};
      6'd17: u = '{SRC_ROLL,  C_DTG,  1'b1, 1'b1, 1'b0, DST_VY};
      6'd18: u = '{SRC_EY,    C_VY,   1'b1, 1'b0, 1'b1, DST_VY};
      6'd19: u = '{SRC_ACCEL, C_DTG,  1'b0, 1'b1, 1'b0, DST_VZ};
      6'd20: u = '{SRC_ONE,   C_DTG,  1'b1, 1'b0, 1'b0, DST_VZ};
      6'd21: u = '{SRC_ER,    C_VZ,   1'b1, 1'b0, 1'b1, DST_VZ};
      6'd22: u = '{SRC_PYD,   G_EY,   1'b0, 1'b1, 1'b0, DST_TX};
      6'd23: u = '{SRC_ROLL,  G_PHI,  1'b1, 1'b0, 1'b0, DST_TX};
      6'd24: u = '{SRC_VY,    G_VY,   1'b0, 1'b0, 1'b0, DST_TX};
      6'd25: u = '{SRC_WX,    G_WX,   1'b1, 1'b0, 1'b1, DST_TX};
      6'd26: u = '{SRC_PXD,   G_EX,   1'b1, 1'b1, 1'b0, DST_TY};
      6'd27: u = '{SRC_PITCH, G_TH,   1'b1, 1'b0, 1'b0, DST_TY};
      6'd28: u = '{SRC_VX,    G_VX,   1'b1, 1'b0, 1'b0, DST_TY};
      6'd29: u = '{SRC_WY,    G_WY,   1'b1, 1'b0, 1'b1, DST_TY};
      6'd30: u = '{SRC_YAW,   G_PSI,  1'b1, 1'b1, 1'b0, DST_TZ};
      6'd31: u = '{SRC_WZ,    G_WZ,   1'b1, 1'b0, 1'b1, DST_TZ};
      6'd32: u = '{SRC_PZD,   G_EZ,   1'b1, 1'b1, 1'b0, DST_FZ};
      6'd33: u = '{SRC_VZ,    G_VZ,   1'b1, 1'b0, 1'b0, DST_FZ};
      6'd34: u = '{SRC_ONE,   G_F0,   1'b0, 1'b0, 1'b1, DST_FZ};
      default: u = '{SRC_ONE, K_UNIT, 1'b0, 1'b1, 1'b0, DST_PX};
    endcase
    return u;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W+1:0] v);
    logic signed [ACC_W+1:0] hi;
    logic signed [ACC_W+1:0] lo;
    hi = (ACC_W+2)'(64'sh7FFF_FFFF);
    lo = -(ACC_W+2)'(64'sh8000_0000);
    if (v > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/qosf_if.sv -----
// Request and result channel interfaces of the quadrotor observer and controller.
// Depends on nothing; instantiated by the parent of the top level.
`default_nettype none

interface qosf_req_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_des_x;
  logic signed [31:0] pos_des_y;
  logic signed [31:0] pos_des_z;
  logic signed [31:0] gyro_x;
  logic signed [31:0] gyro_y;
  logic signed [31:0] gyro_z;
  logic signed [31:0] accel_z;
  logic signed [31:0] flow_dx;
  logic signed [31:0] flow_dy;
  logic signed [31:0] range_dist;
  logic               motors_enable;
  logic               reset_estimate;

  modport source (
    output valid, pos_des_x, pos_des_y, pos_des_z, gyro_x, gyro_y, gyro_z, accel_z,
           flow_dx, flow_dy, range_dist, motors_enable, reset_estimate,
    input  ready
  );
  modport sink (
    input  valid, pos_des_x, pos_des_y, pos_des_z, gyro_x, gyro_y, gyro_z, accel_z,
           flow_dx, flow_dy, range_dist, motors_enable, reset_estimate,
    output ready
  );
endinterface

interface qosf_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] motor_1;
  logic [15:0] motor_2;
  logic [15:0] motor_3;
  logic [15:0] motor_4;

  modport source (output valid, motor_1, motor_2, motor_3, motor_4, input ready);
  modport sink (input valid, motor_1, motor_2, motor_3, motor_4, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/qosf_alu.sv -----
// Shared multiply-accumulate unit: a registered product followed by a 64-bit accumulator.
// Depends on qosf_pkg.
`default_nettype none

module qosf_alu import qosf_pkg::*; (
  input  logic                    clk_i,
  input  alu_ctl_t                ctl_i,
  input  logic signed [OPA_W-1:0] opa_i,
  input  logic signed [31:0]      coef_i,
  output logic signed [ACC_W-1:0] acc_o
);

  logic signed [OPA_W+31:0] prod_full;
  logic signed [ACC_W-1:0]  prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  acc_d;
  logic signed [ACC_W-1:0]  base;

  assign prod_full = opa_i * coef_i;
  assign base      = ctl_i.first ? '0 : acc_q;
  assign acc_d     = ctl_i.neg ? base - prod_q : base + prod_q;
  assign acc_o     = acc_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      prod_q <= prod_full[ACC_W-1:0];
    end
    if (ctl_i.acc_en) begin
      acc_q <= acc_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/quadrotor_observer_state_feedback.sv -----
// Quadrotor observer and state-feedback controller: one request is one control tick.
// A nine-element linear observer is advanced with fixed gains, then state feedback is
// mixed into four motor commands saturated to 0..65535.
// Request channel req_i carries setpoint, gyro, acceleration, flow, range and two flags;
// result channel res_o carries the four motor commands, one result per request.
// Every product and sum runs through one shared multiply-accumulate unit under a step
// sequencer. A tick has 35 multiply steps, each a multiply state and an accumulate state,
// plus a write-back state for each of 19 results, then the four motor commands are mixed
// one by one and handed over; the request side is ready again in the cycle after the
// result is registered. The request side is not ready while a tick is in progress.
// The result sits in an output register; if the receiver stalls, the next tick is
// still taken and computed, and waits at its end until the register is free.
// With motors disabled the result is all zero, but the estimate is still advanced.
// Reset clears the estimate and the handshake state; no result is pending afterwards.
`default_nettype none

module quadrotor_observer_state_feedback import qosf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  qosf_req_if.sink  req_i,
  qosf_res_if.source res_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_WB   = 3'd3;
  localparam logic [2:0] S_MIX  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  localparam logic [3:0] EST_PX    = 4'd0;
  localparam logic [3:0] EST_PY    = 4'd1;
  localparam logic [3:0] EST_PZ    = 4'd2;
  localparam logic [3:0] EST_YAW   = 4'd3;
  localparam logic [3:0] EST_PITCH = 4'd4;
  localparam logic [3:0] EST_ROLL  = 4'd5;
  localparam logic [3:0] EST_VX    = 4'd6;
  localparam logic [3:0] EST_VY    = 4'd7;
  localparam logic [3:0] EST_VZ    = 4'd8;

  logic [2:0] state_q, state_d;
  logic [5:0] step_q, step_d;
  logic [1:0] mix_q, mix_d;

  logic signed [31:0] dx_q, dy_q, dz_q, gx_q, gy_q, gz_q, az_q, nx_q, ny_q, rg_q;
  logic               en_q;

  logic signed [31:0] est_q [9];
  logic signed [31:0] wx_q, wy_q, wz_q, ex_q, ey_q, er_q;
  logic signed [ACC_W-1:0] tx_q, ty_q, tz_q, fz_q;
  logic [15:0] motor_q [4];

  logic        res_valid_q;
  logic [15:0] res_m1_q, res_m2_q, res_m3_q, res_m4_q;

  uop_t                    uop;
  alu_ctl_t                ctl;
  logic signed [OPA_W-1:0] opa;
  logic signed [ACC_W-1:0] acc;
  logic signed [33:0]      rnd30;
  logic signed [39:0]      rnd24;
  logic signed [31:0]      est_old;
  logic signed [31:0]      wb_val;
  logic signed [ACC_W+1:0] mix_sum;
  logic signed [ACC_W+1:0] mix_sh;
  logic [15:0]             motor_val;
  logic                    req_fire;

  assign uop      = get_uop(step_q);
  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire = req_i.valid && req_i.ready;

  always_comb begin
    unique case (uop.src)
      SRC_GX:    opa = OPA_W'(gx_q);
      SRC_GY:    opa = OPA_W'(gy_q);
      SRC_GZ:    opa = OPA_W'(gz_q);
      SRC_ACCEL: opa = OPA_W'(az_q);
      SRC_FX:    opa = (OPA_W'(est_q[EST_VX]) <<< 1) - OPA_W'(wy_q);
      SRC_FY:    opa = (OPA_W'(est_q[EST_VY]) <<< 1) + OPA_W'(wx_q);
      SRC_RNG:   opa = OPA_W'(est_q[EST_PZ]) - OPA_W'(rg_q);
      SRC_VX:    opa = OPA_W'(est_q[EST_VX]);
      SRC_VY:    opa = OPA_W'(est_q[EST_VY]);
      SRC_VZ:    opa = OPA_W'(est_q[EST_VZ]);
      SRC_WX:    opa = OPA_W'(wx_q);
      SRC_WY:    opa = OPA_W'(wy_q);
      SRC_WZ:    opa = OPA_W'(wz_q);
      SRC_EX:    opa = OPA_W'(ex_q);
      SRC_EY:    opa = OPA_W'(ey_q);
      SRC_ER:    opa = OPA_W'(er_q);
      SRC_PITCH: opa = OPA_W'(est_q[EST_PITCH]);
      SRC_ROLL:  opa = OPA_W'(est_q[EST_ROLL]);
      SRC_YAW:   opa = OPA_W'(est_q[EST_YAW]);
      SRC_ONE:   opa = OPA_W'(1) <<< FRAC_BITS;
      SRC_PXD:   opa = OPA_W'(est_q[EST_PX]) - OPA_W'(dx_q);
      SRC_PYD:   opa = OPA_W'(est_q[EST_PY]) - OPA_W'(dy_q);
      SRC_PZD:   opa = OPA_W'(est_q[EST_PZ]) - OPA_W'(dz_q);
      default:   opa = '0;
    endcase
  end

  assign ctl.mul_en = (state_q == S_MUL);
  assign ctl.acc_en = (state_q == S_ACC);
  assign ctl.first  = uop.first;
  assign ctl.neg    = uop.neg;

  qosf_alu u_alu (
    .clk_i  (clk_i),
    .ctl_i  (ctl),
    .opa_i  (opa),
    .coef_i (uop.coef),
    .acc_o  (acc)
  );

  // Round half up at the fraction boundary but for the range error; saturate per destination.
  always_comb begin
    logic signed [ACC_W-1:0] a30;
    logic signed [ACC_W-1:0] a24;
    a30     = (acc + (ACC_W'(1) <<< 29)) >>> 30;
    a24     = (acc + (ACC_W'(1) <<< 23)) >>> 24;
    rnd30   = a30[33:0];
    rnd24   = a24[39:0];
    est_old = est_q[uop.dst[3:0]];
    priority if (uop.dst <= DST_VZ) begin
      wb_val = sat32((ACC_W+2)'(est_old) + (ACC_W+2)'(rnd30));
    end else if (uop.dst == DST_EX) begin
      wb_val = sat32((ACC_W+2)'(rnd24) - (ACC_W+2)'(nx_q));
    end else if (uop.dst == DST_EY) begin
      wb_val = sat32((ACC_W+2)'(rnd24) - (ACC_W+2)'(ny_q));
    end else if (uop.dst == DST_ER) begin
      wb_val = sat32((ACC_W+2)'(acc));
    end else begin
      wb_val = sat32((ACC_W+2)'(rnd30));
    end
  end

  // Motor order: tx enters positively for motors three and four, ty for two and
  // three, tz for two and four; fz always enters positively.
  always_comb begin
    logic signed [ACC_W+1:0] ttx, tty, ttz, tfz;
    ttx     = (ACC_W+2)'(tx_q);
    tty     = (ACC_W+2)'(ty_q);
    ttz     = (ACC_W+2)'(tz_q);
    tfz     = (ACC_W+2)'(fz_q);
    mix_sum = tfz + (mix_q[1] ? ttx : -ttx) + ((mix_q[1] ^ mix_q[0]) ? tty : -tty)
            + (mix_q[0] ? ttz : -ttz);
    mix_sh  = mix_sum >>> MOTOR_SH;
    if (!en_q || mix_sum < 0) begin
      motor_val = '0;
    end else if (mix_sh > (ACC_W+2)'(65535)) begin
      motor_val = 16'hFFFF;
    end else begin
      motor_val = mix_sh[15:0];
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    mix_d   = mix_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          state_d = S_MUL;
          step_d  = '0;
        end
      end
      S_MUL: state_d = S_ACC;
      S_ACC: begin
        if (uop.last) begin
          state_d = S_WB;
        end else begin
          state_d = S_MUL;
          step_d  = step_q + 6'd1;
        end
      end
      S_WB: begin
        if (step_q == N_STEPS - 6'd1) begin
          state_d = S_MIX;
          mix_d   = '0;
        end else begin
          state_d = S_MUL;
          step_d  = step_q + 6'd1;
        end
      end
      S_MIX: begin
        mix_d = mix_q + 2'd1;
        if (mix_q == 2'd3) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!res_valid_q || res_o.ready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      mix_q       <= '0;
      res_valid_q <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        est_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      mix_q   <= mix_d;
      if (req_fire && req_i.reset_estimate) begin
        for (int i = 0; i < 9; i++) begin
          est_q[i] <= '0;
        end
      end else if (state_q == S_WB && uop.dst <= DST_VZ) begin
        est_q[uop.dst[3:0]] <= wb_val;
      end
      if (state_q == S_DONE && (!res_valid_q || res_o.ready)) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      dx_q <= req_i.pos_des_x;
      dy_q <= req_i.pos_des_y;
      dz_q <= req_i.pos_des_z;
      gx_q <= req_i.gyro_x;
      gy_q <= req_i.gyro_y;
      gz_q <= req_i.gyro_z;
      az_q <= req_i.accel_z;
      nx_q <= req_i.flow_dx;
      ny_q <= req_i.flow_dy;
      rg_q <= req_i.range_dist;
      en_q <= req_i.motors_enable;
    end
    if (state_q == S_WB) begin
      unique case (uop.dst)
        DST_WX:  wx_q <= wb_val;
        DST_WY:  wy_q <= wb_val;
        DST_WZ:  wz_q <= wb_val;
        DST_EX:  ex_q <= wb_val;
        DST_EY:  ey_q <= wb_val;
        DST_ER:  er_q <= wb_val;
        DST_TX:  tx_q <= acc;
        DST_TY:  ty_q <= acc;
        DST_TZ:  tz_q <= acc;
        DST_FZ:  fz_q <= acc;
        default: ;
      endcase
    end
    if (state_q == S_MIX) begin
      motor_q[mix_q] <= motor_val;
    end
    if (state_q == S_DONE && (!res_valid_q || res_o.ready)) begin
      res_m1_q <= motor_q[0];
      res_m2_q <= motor_q[1];
      res_m3_q <= motor_q[2];
      res_m4_q <= motor_q[3];
    end
  end

  assign res_o.valid   = res_valid_q;
  assign res_o.motor_1 = res_m1_q;
  assign res_o.motor_2 = res_m2_q;
  assign res_o.motor_3 = res_m3_q;
  assign res_o.motor_4 = res_m4_q;

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// Self-checking testbench of quadrotor_observer_state_feedback: observer update, state
// feedback and motor mixing are predicted per control tick and compared result by result.
// Depends on qosf_pkg and the request and result interfaces in qosf_if.sv.
`timescale 1ns / 1ps

module testbench;
  import qosf_pkg::*;

  typedef struct {
    logic signed [31:0] pos_des_x, pos_des_y, pos_des_z;
    logic signed [31:0] gyro_x, gyro_y, gyro_z, accel_z;
    logic signed [31:0] flow_dx, flow_dy, range_dist;
    logic               motors_enable, reset_estimate;
  } tick_t;

  typedef struct packed {
    logic [15:0] m1, m2, m3, m4;
  } motors_t;

  function automatic longint qk(longint unsigned n, longint unsigned d, int s);
    return longint'(((n << s) + d / 2) / d);
  endfunction

  localparam longint E9      = 1000000000;
  localparam longint DEG2RAD = 18740330;
  localparam longint KF      = qk(409255568, 100000000, 24);
  localparam longint K_DT    = qk(2000000, E9, 30);
  localparam longint K_DTG   = qk(19620000, E9, 30);
  localparam longint K_OZ    = qk(39983330, E9, 30);
  localparam longint K_TH    = qk(7462, E9, 30);
  localparam longint K_PH    = qk(4308, E9, 30);
  localparam longint K_VX    = qk(197776, E9, 30);
  localparam longint K_VY    = qk(146924, E9, 30);
  localparam longint K_VZ    = qk(174666666, E9, 30);
  localparam longint F_EY    = qk(64'd35693889 * 64'd198846, E9, 8);
  localparam longint F_PHI   = qk(64'd35693889 * 64'd464423, E9, 8);
  localparam longint F_VY    = qk(64'd35693889 * 64'd150935, E9, 8);
  localparam longint F_WX    = qk(64'd35693889 * 64'd73568, E9, 8);
  localparam longint F_EX    = qk(64'd35693889 * 64'd198846, E9, 8);
  localparam longint F_TH    = qk(64'd35693889 * 64'd514773, E9, 8);
  localparam longint F_VX    = qk(64'd35693889 * 64'd157552, E9, 8);
  localparam longint F_WY    = qk(64'd35693889 * 64'd74979, E9, 8);
  localparam longint F_PSI   = qk(64'd391236307 * 64'd33122, E9, 8);
  localparam longint F_WZ    = qk(64'd391236307 * 64'd15339, E9, 8);
  localparam longint F_EZ    = qk(64'd1213592 * 64'd18494275, E9, 8);
  localparam longint F_VZ    = qk(64'd1213592 * 64'd21387905, E9, 8);
  localparam longint F_F0    = qk(64'd1213592 * 64'd30607200, E9, 8);
  localparam int     N_TICKS = 1650;
  localparam int     LIMIT   = 3000000;

  class motor_scoreboard;
    longint px, py, pz, yaw, pitch, roll, vx, vy, vz;
    motors_t expected_motors[$];
    int mismatches;
    int failures;

    function new();
      clear_estimate();
      mismatches = 0;
      failures = 0;
    endfunction

    function void clear_estimate();
      px = 0; py = 0; pz = 0; yaw = 0; pitch = 0; roll = 0; vx = 0; vy = 0; vz = 0;
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint round_sh(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function logic [15:0] motor_cmd(longint sum);
      longint m;
      if (sum < 0) return 16'd0;
      m = sum >>> (FRAC_BITS + 8);
      return (m > 65535) ? 16'hFFFF : m[15:0];
    endfunction

    function void note_tick(tick_t t);
      longint wx, wy, wz, ex, ey, er, tx, ty, tz, fz, one;
      motors_t m;
      one = 64'sd1 <<< FRAC_BITS;
      wx = clamp32(round_sh(longint'(t.gyro_x) * DEG2RAD, 30));
      wy = clamp32(round_sh(longint'(t.gyro_y) * DEG2RAD, 30));
      wz = clamp32(round_sh(longint'(t.gyro_z) * DEG2RAD, 30));
      if (t.reset_estimate) clear_estimate();
      ex = clamp32(round_sh(KF * (2 * vx - wy), 24) - longint'(t.flow_dx));
      ey = clamp32(round_sh(KF * (2 * vy + wx), 24) - longint'(t.flow_dy));
      er = clamp32(pz - longint'(t.range_dist));
      px = clamp32(px + round_sh(K_DT * vx, 30));
      py = clamp32(py + round_sh(K_DT * vy, 30));
      pz = clamp32(pz + round_sh(K_DT * vz - K_OZ * er, 30));
      yaw = clamp32(yaw + round_sh(K_DT * wz, 30));
      pitch = clamp32(pitch + round_sh(K_DT * wy - K_TH * ex, 30));
      roll = clamp32(roll + round_sh(K_DT * wx + K_PH * ey, 30));
      vx = clamp32(vx + round_sh(K_DTG * pitch - K_VX * ex, 30));
      vy = clamp32(vy + round_sh(-K_DTG * roll - K_VY * ey, 30));
      vz = clamp32(vz + round_sh(K_DTG * longint'(t.accel_z) - K_DTG * one - K_VZ * er, 30));
      if (!t.motors_enable) begin
        m = '{16'd0, 16'd0, 16'd0, 16'd0};
      end else begin
        tx = F_EY * (py - longint'(t.pos_des_y)) - F_PHI * roll + F_VY * vy - F_WX * wx;
        ty = -F_EX * (px - longint'(t.pos_des_x)) - F_TH * pitch - F_VX * vx - F_WY * wy;
        tz = -F_PSI * yaw - F_WZ * wz;
        fz = -F_EZ * (pz - longint'(t.pos_des_z)) - F_VZ * vz + F_F0 * one;
        m.m1 = motor_cmd(-tx - ty - tz + fz);
        m.m2 = motor_cmd(-tx + ty + tz + fz);
        m.m3 = motor_cmd(tx + ty - tz + fz);
        m.m4 = motor_cmd(tx - ty + tz + fz);
      end
      expected_motors.push_back(m);
    endfunction

    function void check_motors(motors_t got);
      motors_t want;
      if (expected_motors.size() == 0) begin
        failures++;
        if (mismatches++ < 10) $display("Unexpected result %h %h %h %h", got.m1, got.m2,
                                        got.m3, got.m4);
        return;
      end
      want = expected_motors.pop_front();
      if (got != want) begin
        failures++;
        if (mismatches++ < 10) begin
          $display("Motor mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                   want.m1, want.m2, want.m3, want.m4, got.m1, got.m2, got.m3, got.m4);
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  int   cycles;
  int   sent;
  motor_scoreboard sb;

  qosf_req_if req ();
  qosf_res_if res ();

  quadrotor_observer_state_feedback dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .res_o  (res)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic signed [31:0] pick_value(int mag);
    case ($urandom_range(0, 9))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2, 3: return $urandom;
      default: return $signed($urandom_range(0, 2 * mag)) - mag;
    endcase
  endfunction

  function automatic tick_t random_tick();
    tick_t t;
    bit wild;
    wild = ($urandom_range(0, 4) == 0);
    t.pos_des_x  = wild ? pick_value(200000) : $signed($urandom_range(0, 262144)) - 131072;
    t.pos_des_y  = wild ? pick_value(200000) : $signed($urandom_range(0, 262144)) - 131072;
    t.pos_des_z  = wild ? pick_value(200000) : $signed($urandom_range(0, 131072));
    t.gyro_x     = wild ? pick_value(1 << 24) : $signed($urandom_range(0, 1 << 23)) - (1 << 22);
    t.gyro_y     = wild ? pick_value(1 << 24) : $signed($urandom_range(0, 1 << 23)) - (1 << 22);
    t.gyro_z     = wild ? pick_value(1 << 24) : $signed($urandom_range(0, 1 << 23)) - (1 << 22);
    t.accel_z    = wild ? pick_value(1 << 20) : 32'sd65536 + $signed($urandom_range(0, 16384)) - 8192;
    t.flow_dx    = wild ? pick_value(1 << 22) : $signed($urandom_range(0, 1 << 20)) - (1 << 19);
    t.flow_dy    = wild ? pick_value(1 << 22) : $signed($urandom_range(0, 1 << 20)) - (1 << 19);
    t.range_dist = wild ? pick_value(1 << 20) : $signed($urandom_range(0, 131072));
    t.motors_enable  = ($urandom_range(0, 9) != 0);
    t.reset_estimate = ($urandom_range(0, 39) == 0);
    return t;
  endfunction

  function automatic tick_t uniform_tick(logic signed [31:0] v, logic en, logic clr);
    tick_t t;
    t = '{v, v, v, v, v, v, v, v, v, v, en, clr};
    return t;
  endfunction

  task automatic send_tick(tick_t t);
    req.pos_des_x      <= t.pos_des_x;
    req.pos_des_y      <= t.pos_des_y;
    req.pos_des_z      <= t.pos_des_z;
    req.gyro_x         <= t.gyro_x;
    req.gyro_y         <= t.gyro_y;
    req.gyro_z         <= t.gyro_z;
    req.accel_z        <= t.accel_z;
    req.flow_dx        <= t.flow_dx;
    req.flow_dy        <= t.flow_dy;
    req.range_dist     <= t.range_dist;
    req.motors_enable  <= t.motors_enable;
    req.reset_estimate <= t.reset_estimate;
    req.valid          <= 1'b1;
    do @(posedge clk_i); while (!req.ready);
    sb.note_tick(t);
    sent++;
  endtask

  task automatic pause_sender(int n);
    req.valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  initial begin
    int burst;
    tick_t t;
    sb = new();
    sent = 0;
    rst_ni = 1'b0;
    req.valid <= 1'b0;
    req.pos_des_x <= '0; req.pos_des_y <= '0; req.pos_des_z <= '0;
    req.gyro_x <= '0; req.gyro_y <= '0; req.gyro_z <= '0; req.accel_z <= '0;
    req.flow_dx <= '0; req.flow_dy <= '0; req.range_dist <= '0;
    req.motors_enable <= 1'b0; req.reset_estimate <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_tick(uniform_tick(32'sd0, 1'b1, 1'b0));
    send_tick(uniform_tick(32'sd0, 1'b0, 1'b1));
    send_tick(uniform_tick(32'sh7FFF_FFFF, 1'b1, 1'b0));
    send_tick(uniform_tick(32'sh7FFF_FFFF, 1'b1, 1'b0));
    send_tick(uniform_tick(32'sh8000_0000, 1'b1, 1'b0));
    send_tick(uniform_tick(32'sh8000_0000, 1'b0, 1'b0));
    send_tick(uniform_tick(32'shFFFF_FFFF, 1'b1, 1'b1));
    send_tick(uniform_tick(32'sh5555_5555, 1'b1, 1'b0));
    send_tick(uniform_tick(32'shAAAA_AAAA, 1'b1, 1'b1));
    send_tick(uniform_tick(32'sd65536, 1'b1, 1'b1));
    t = uniform_tick(32'sd0, 1'b1, 1'b1);
    t.pos_des_z = 32'sh7FFF_FFFF;
    send_tick(t);
    t.pos_des_z = 32'sh8000_0000;
    send_tick(t);
    t = uniform_tick(32'sd0, 1'b1, 1'b1);
    t.accel_z = 32'sd65536;
    repeat (3) begin
      send_tick(t);
      t.reset_estimate = 1'b0;
    end
    t.gyro_x = 32'sh7FFF_FFFF; t.flow_dy = 32'sh8000_0000;
    send_tick(t);
    t.gyro_y = 32'sh8000_0000; t.flow_dx = 32'sh7FFF_FFFF; t.range_dist = 32'sh8000_0000;
    send_tick(t);
    t.motors_enable = 1'b0;
    send_tick(t);
    t.motors_enable = 1'b1;
    t.gyro_z = 32'sh7FFF_FFFF;
    send_tick(t);

    while (sent < N_TICKS) begin
      burst = $urandom_range(1, 20);
      repeat (burst) send_tick(random_tick());
      if (sent >= 900 && sent < 900 + burst) begin
        req.valid <= 1'b0;
        while (sb.expected_motors.size() != 0) @(posedge clk_i);
      end
      if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 150));
    end
    req.valid <= 1'b0;
    while (sb.expected_motors.size() != 0) @(posedge clk_i);
    repeat (250) @(posedge clk_i);
    if (sb.failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    int span;
    int style;
    bit held;
    held = 1'b0;
    res.ready <= 1'b0;
    forever begin
      if (!held && sent >= 400) begin
        held = 1'b1;
        res.ready <= 1'b0;
        for (int n = 0; n < 700; n++) begin
          @(posedge clk_i);
          if (res.valid && res.ready) sb.check_motors('{res.motor_1, res.motor_2,
                                                         res.motor_3, res.motor_4});
        end
      end
      span = $urandom_range(50, 400);
      style = $urandom_range(0, 2);
      repeat (span) begin
        case (style)
          0: res.ready <= 1'b1;
          1: res.ready <= $urandom_range(0, 1);
          default: res.ready <= ($urandom_range(0, 7) == 0);
        endcase
        @(posedge clk_i);
        if (res.valid && res.ready) sb.check_motors('{res.motor_1, res.motor_2,
                                                       res.motor_3, res.motor_4});
      end
    end
  end

endmodule
